### design/kwbr_pkg.sv
package kwbr_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       got_valid;
    logic [1:0] got_field;
    logic [7:0] got_byte;
    logic [7:0] data_index;
    logic       done_res;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  byte_timeout;
    logic [15:0] block_timeout;
    logic [7:0]  answer_delay;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FIRST = 3'd1,
    PH_BYTE  = 3'd2,
    PH_DELAY = 3'd3,
    PH_ECHO  = 3'd4,
    PH_END   = 3'd5
  } phase_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_START  = 3'd1;
  localparam logic [2:0] ST_BYTE_TO   = 3'd2;
  localparam logic [2:0] ST_ECHO_BAD  = 3'd3;
  localparam logic [2:0] ST_END_TO    = 3'd4;
  localparam logic [2:0] ST_WRONG_END = 3'd5;

  localparam logic [1:0] REG_BYTE_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_BLOCK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ANSWER_DELAY  = 2'd2;

  localparam logic [1:0] FIELD_DATA = 2'd3;
  localparam logic [7:0] HDR_BYTES  = 8'd3;
  localparam logic [7:0] END_MARK   = 8'h03;

  localparam logic [7:0]  RST_BYTE_TIMEOUT  = 8'd40;
  localparam logic [15:0] RST_BLOCK_TIMEOUT = 16'd500;
  localparam logic [7:0]  RST_ANSWER_DELAY  = 8'd2;

endpackage

### design/kwbr_cfg.sv
module kwbr_cfg
  import kwbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_BYTE_TIMEOUT:  cfg_nxt.byte_timeout = cfg_data[7:0];
        REG_BLOCK_TIMEOUT: cfg_nxt.block_timeout = cfg_data;
        REG_ANSWER_DELAY:  cfg_nxt.answer_delay = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.byte_timeout  <= RST_BYTE_TIMEOUT;
      cfg_r.block_timeout <= RST_BLOCK_TIMEOUT;
      cfg_r.answer_delay  <= RST_ANSWER_DELAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/kwbr_in_stage.sv
module kwbr_in_stage
  import kwbr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     out_free,
  output logic     fire,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign fire = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

endmodule

### design/kwbr_step.sv
module kwbr_step
  import kwbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [7:0]  echo_r, echo_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;

  logic [1:0] field;
  logic [7:0] idx;
  logic [8:0] next_pos;
  logic [8:0] end_pos;
  logic       cd_expired;

  assign field = (pos_r < HDR_BYTES) ? pos_r[1:0] : FIELD_DATA;
  assign idx = (pos_r >= HDR_BYTES) ? (pos_r - HDR_BYTES) : 8'd0;
  assign next_pos = {1'b0, pos_r} + 9'd1;
  assign end_pos = {1'b0, (len_r > HDR_BYTES) ? len_r : HDR_BYTES};
  assign cd_expired = (countdown_r <= 16'd1);

  always_comb begin
    phase_nxt = phase_r;
    countdown_nxt = countdown_r;
    echo_nxt = echo_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    res_valid = 1'b0;
    res = '0;
    case (item.action)
      ACT_START: begin
        phase_nxt = PH_FIRST;
        countdown_nxt = cfg.block_timeout;
        pos_nxt = 8'd0;
        len_nxt = 8'd0;
        echo_nxt = 8'd0;
      end
      ACT_TICK: begin
        case (phase_r)
          PH_FIRST, PH_BYTE, PH_END: begin
            if (cd_expired) begin
              phase_nxt = PH_IDLE;
              countdown_nxt = 16'd0;
              res_valid = 1'b1;
              res.done_res = 1'b1;
              res.status = (phase_r == PH_FIRST) ? ST_NO_START :
                           (phase_r == PH_BYTE) ? ST_BYTE_TO : ST_END_TO;
            end else begin
              countdown_nxt = countdown_r - 16'd1;
            end
          end
          PH_DELAY: begin
            if (cd_expired) begin
              phase_nxt = PH_ECHO;
              countdown_nxt = 16'd0;
              res_valid = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte = echo_r;
            end else begin
              countdown_nxt = countdown_r - 16'd1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      ACT_BYTE: begin
        case (phase_r)
          PH_FIRST, PH_BYTE: begin
            if (pos_r == 8'd0) begin
              len_nxt = item.rx_byte;
            end
            echo_nxt = ~item.rx_byte;
            res_valid = 1'b1;
            res.got_valid = 1'b1;
            res.got_field = field;
            res.got_byte = item.rx_byte;
            res.data_index = idx;
            if (cfg.answer_delay == 8'd0) begin
              countdown_nxt = 16'd0;
              phase_nxt = PH_ECHO;
              res.tx_valid = 1'b1;
              res.tx_byte = ~item.rx_byte;
            end else begin
              countdown_nxt = {8'd0, cfg.answer_delay};
              phase_nxt = PH_DELAY;
            end
          end
          PH_ECHO: begin
            if (item.rx_byte != echo_r) begin
              phase_nxt = PH_IDLE;
              countdown_nxt = 16'd0;
              res_valid = 1'b1;
              res.done_res = 1'b1;
              res.status = ST_ECHO_BAD;
            end else begin
              pos_nxt = next_pos[7:0];
              phase_nxt = (next_pos >= end_pos) ? PH_END : PH_BYTE;
              countdown_nxt = {8'd0, cfg.byte_timeout};
            end
          end
          PH_END: begin
            phase_nxt = PH_IDLE;
            countdown_nxt = 16'd0;
            res_valid = 1'b1;
            res.done_res = 1'b1;
            res.status = (item.rx_byte == END_MARK) ? ST_OK : ST_WRONG_END;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      countdown_r <= 16'd0;
      echo_r <= 8'd0;
      pos_r <= 8'd0;
      len_r <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      countdown_r <= countdown_nxt;
      echo_r <= echo_nxt;
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

### design/kwbr_out_stage.sv
module kwbr_out_stage
  import kwbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign out_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = res_valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      item_r <= res;
    end
  end

endmodule

### design/kw1281_block_receiver_top.sv
// An accepted item waits in the input register until the result register is free;
// its result, if it has one, is then registered in the result register.
// Throughput: one item per cycle while out_stall is low; a stalled result register
// also holds the input register. The block state advances once per item.
// Reset (synchronous, rst_n low) returns the receiver to idle, empties both
// registers and loads the timing registers with their default values.
module kw1281_block_receiver_top
  import kwbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  logic      out_free;
  logic      fire;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  kwbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kwbr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  kwbr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  kwbr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### design/kwbr_checker.sv
module kwbr_checker
  import kwbr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'd0)
    else $error("Complement byte set without tx_valid.");

  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_res |-> !out_item.got_valid && !out_item.tx_valid)
    else $error("Finished item also carries a block byte or complement.");

  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.done_res |-> out_item.status == ST_OK)
    else $error("Status set on an unfinished item.");

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.tx_valid || out_item.got_valid || out_item.done_res)
    else $error("Empty result item.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed.");

endmodule

bind kw1281_block_receiver_top kwbr_checker u_kwbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### tb/kw1281_block_receiver_top_tb.sv
`timescale 1ns / 1ps

module kw1281_block_receiver_top_tb;
  import kwbr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Expected state of the receiver and its timing registers.
  cfg_t timing = '{byte_timeout: RST_BYTE_TIMEOUT, block_timeout: RST_BLOCK_TIMEOUT,
                   answer_delay: RST_ANSWER_DELAY};
  phase_t      rx_phase = PH_IDLE;
  logic [15:0] rx_count = '0;
  logic [7:0]  rx_echo = '0;
  logic [7:0]  rx_pos = '0;
  logic [7:0]  rx_len = '0;

  out_item_t due_reports[$];
  int  mismatches = 0;
  int  sent_items = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;
  logic hold_off = 1'b0;

  kw1281_block_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic in_item_t event_item(input logic [1:0] act, input logic [7:0] b);
    in_item_t it;
    it.action = act;
    it.rx_byte = b;
    return it;
  endfunction

  // Advances the expected receiver state by one item; returns 1 when it reports.
  function automatic bit receiver_reaction(input in_item_t it, output out_item_t rep);
    int ndata;
    int nxt;
    bit has_rep;
    bit closes;
    logic [2:0] fin;
    rep = '0;
    has_rep = 1'b0;
    closes = 1'b0;
    fin = ST_OK;
    case (it.action)
      ACT_START: begin
        rx_phase = PH_FIRST;
        rx_count = timing.block_timeout;
        rx_pos = '0;
        rx_len = '0;
        rx_echo = '0;
      end
      ACT_TICK: begin
        if (rx_phase == PH_FIRST || rx_phase == PH_BYTE || rx_phase == PH_END) begin
          if (rx_count <= 16'd1) begin
            closes = 1'b1;
            fin = (rx_phase == PH_FIRST) ? ST_NO_START :
                  (rx_phase == PH_BYTE) ? ST_BYTE_TO : ST_END_TO;
          end else begin
            rx_count = rx_count - 16'd1;
          end
        end else if (rx_phase == PH_DELAY) begin
          if (rx_count <= 16'd1) begin
            rx_count = '0;
            rx_phase = PH_ECHO;
            rep.tx_valid = 1'b1;
            rep.tx_byte = rx_echo;
            has_rep = 1'b1;
          end else begin
            rx_count = rx_count - 16'd1;
          end
        end
      end
      ACT_BYTE: begin
        if (rx_phase == PH_FIRST || rx_phase == PH_BYTE) begin
          rep.got_valid = 1'b1;
          rep.got_field = (rx_pos < HDR_BYTES) ? rx_pos[1:0] : FIELD_DATA;
          rep.got_byte = it.rx_byte;
          rep.data_index = (rx_pos >= HDR_BYTES) ? rx_pos - HDR_BYTES : 8'd0;
          if (rx_pos == 8'd0) rx_len = it.rx_byte;
          rx_echo = 8'd255 - it.rx_byte;
          if (timing.answer_delay == 8'd0) begin
            rx_count = '0;
            rx_phase = PH_ECHO;
            rep.tx_valid = 1'b1;
            rep.tx_byte = rx_echo;
          end else begin
            rx_count = {8'd0, timing.answer_delay};
            rx_phase = PH_DELAY;
          end
          has_rep = 1'b1;
        end else if (rx_phase == PH_ECHO) begin
          if (it.rx_byte != rx_echo) begin
            closes = 1'b1;
            fin = ST_ECHO_BAD;
          end else begin
            ndata = (rx_len > HDR_BYTES) ? int'(rx_len) - int'(HDR_BYTES) : 0;
            nxt = int'(rx_pos) + 1;
            rx_pos = nxt[7:0];
            rx_phase = (nxt >= int'(HDR_BYTES) + ndata) ? PH_END : PH_BYTE;
            rx_count = {8'd0, timing.byte_timeout};
          end
        end else if (rx_phase == PH_END) begin
          closes = 1'b1;
          fin = (it.rx_byte == END_MARK) ? ST_OK : ST_WRONG_END;
        end
      end
      default: ;
    endcase
    if (closes) begin
      rx_phase = PH_IDLE;
      rx_count = '0;
      rep.done_res = 1'b1;
      rep.status = fin;
      has_rep = 1'b1;
    end
    return has_rep;
  endfunction

  // Chooses the next item from the expected phase, so that most blocks run deep.
  function automatic void pick_stimulus(input bit clean, input bit long_block,
                                        output in_item_t it, output bit counts);
    int roll;
    int len_roll;
    roll = $urandom_range(0, 99);
    len_roll = $urandom_range(0, 99);
    it.action = ACT_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));
    counts = 1'b1;
    case (rx_phase)
      PH_IDLE: begin
        if (clean || roll < 85) begin
          it.action = ACT_START;
        end else begin
          it.action = (roll < 90) ? ACT_TICK : (roll < 95) ? ACT_BYTE : ACT_UNUSED;
          counts = 1'b0;
        end
      end
      PH_FIRST, PH_BYTE: begin
        if (clean || roll < 78) begin
          it.action = ACT_BYTE;
          if (rx_phase == PH_FIRST) begin
            if (long_block) it.rx_byte = 8'hFF;
            else if (len_roll < 70) it.rx_byte = 8'($urandom_range(0, 8));
            else if (len_roll < 97) it.rx_byte = 8'($urandom_range(9, 24));
          end
        end else if (roll < 96) begin
          it.action = ACT_TICK;
        end else begin
          it.action = ACT_START;
        end
      end
      PH_DELAY: begin
        if (clean || roll < 92) begin
          it.action = ACT_TICK;
        end else if (roll < 96) begin
          it.action = ACT_BYTE;
          counts = 1'b0;
        end else begin
          it.action = ACT_START;
        end
      end
      PH_ECHO: begin
        if (clean || roll < 88) begin
          it.action = ACT_BYTE;
          it.rx_byte = rx_echo;
        end else if (roll < 93) begin
          it.action = ACT_BYTE;
          it.rx_byte = rx_echo ^ 8'($urandom_range(1, 255));
        end else if (roll < 98) begin
          it.action = ACT_TICK;
          counts = 1'b0;
        end else begin
          it.action = ACT_START;
        end
      end
      PH_END: begin
        if (clean || roll < 70) begin
          it.action = ACT_BYTE;
          it.rx_byte = END_MARK;
        end else if (roll < 85) begin
          it.action = ACT_BYTE;
        end else begin
          it.action = ACT_TICK;
        end
      end
      default: counts = 1'b0;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    out_item_t rep;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (receiver_reaction(it, rep)) due_reports.push_back(rep);
    sent_items++;
    if (sent_items % 64 == 0) idle_on = 1'($urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic wait_cfg();
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_timing(input logic [7:0] bt, input logic [15:0] blkt,
                                input logic [7:0] ad);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_BYTE_TIMEOUT;
    cfg_data <= {8'd0, bt};
    wait_cfg();
    cfg_index <= REG_BLOCK_TIMEOUT;
    cfg_data <= blkt;
    wait_cfg();
    cfg_index <= REG_ANSWER_DELAY;
    cfg_data <= {8'd0, ad};
    wait_cfg();
    cfg_valid <= 1'b0;
    timing.byte_timeout = bt;
    timing.block_timeout = blkt;
    timing.answer_delay = ad;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t exp_r;
    if (due_reports.size() == 0) begin
      mismatches++;
      $display("%0t: expected no result, got %p", $time, got);
    end else begin
      exp_r = due_reports.pop_front();
      check_field("tx_valid", 16'(exp_r.tx_valid), 16'(got.tx_valid));
      check_field("tx_byte", 16'(exp_r.tx_byte), 16'(got.tx_byte));
      check_field("got_valid", 16'(exp_r.got_valid), 16'(got.got_valid));
      check_field("got_field", 16'(exp_r.got_field), 16'(got.got_field));
      check_field("got_byte", 16'(exp_r.got_byte), 16'(got.got_byte));
      check_field("data_index", 16'(exp_r.data_index), 16'(got.data_index));
      check_field("done_res", 16'(exp_r.done_res), 16'(got.done_res));
      check_field("status", 16'(exp_r.status), 16'(got.status));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_report(out_item);
      stall_left = idle_on ? $urandom_range(0, 8) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= hold_off || (stall_left != 0);
  end

  task automatic test_idle_noise();
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_BYTE, 8'hFF));
    send_item(event_item(ACT_UNUSED, 8'h00));
  endtask

  // A block of length zero under the default timing, with an abort at its start.
  task automatic test_short_block();
    send_item(event_item(ACT_START, 8'hFF));
    send_item(event_item(ACT_BYTE, 8'h00));
    send_item(event_item(ACT_START, 8'h00));
    send_item(event_item(ACT_BYTE, 8'h00));
    send_item(event_item(ACT_BYTE, 8'h55));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_TICK, 8'hFF));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_BYTE, 8'hFF));
    send_item(event_item(ACT_BYTE, 8'h01));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_BYTE, 8'hFE));
    send_item(event_item(ACT_BYTE, 8'hFF));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_BYTE, 8'h00));
    send_item(event_item(ACT_BYTE, END_MARK));
  endtask

  task automatic test_timeouts();
    program_timing(8'd0, 16'd1, 8'd0);
    send_item(event_item(ACT_START, 8'h00));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_START, 8'h00));
    send_item(event_item(ACT_BYTE, 8'h02));
    send_item(event_item(ACT_BYTE, 8'hFD));
    send_item(event_item(ACT_TICK, 8'h00));
    send_item(event_item(ACT_START, 8'h00));
    send_item(event_item(ACT_BYTE, 8'h80));
    send_item(event_item(ACT_BYTE, 8'h00));
  endtask

  task automatic test_long_block();
    in_item_t it;
    bit counts;
    program_timing(8'd255, 16'd65535, 8'd0);
    do begin
      pick_stimulus(1'b1, 1'b1, it, counts);
      send_item(it);
    end while (rx_phase != PH_IDLE);
  endtask

  task automatic test_backpressure();
    program_timing(8'd40, 16'd1, 8'd2);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        repeat (40) begin
          send_item(event_item(ACT_START, 8'($urandom_range(0, 255))));
          send_item(event_item(ACT_TICK, 8'($urandom_range(0, 255))));
        end
      end
    join
  endtask

  task automatic run_random(input int n_items);
    in_item_t it;
    bit counts;
    int counted;
    counted = 0;
    while (counted < n_items) begin
      pick_stimulus(1'b0, 1'b0, it, counts);
      send_item(it);
      if (counts) counted++;
    end
  endtask

  task automatic test_random_settings();
    program_timing(8'd40, 16'd500, 8'd2);
    run_random(180);
    program_timing(8'd1, 16'd1, 8'd0);
    run_random(100);
    program_timing(8'd255, 16'd65535, 8'd1);
    run_random(100);
    program_timing(8'd2, 16'd3, 8'd255);
    run_random(60);
  endtask

  initial begin
    int spin;
    spin = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_noise();
    test_short_block();
    test_timeouts();
    test_long_block();
    test_backpressure();
    test_random_settings();
    in_valid <= 1'b0;
    while (due_reports.size() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (due_reports.size() != 0) begin
      mismatches += due_reports.size();
      $display("%0t: %0d expected results never arrived", $time, due_reports.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
